// ===== rtl/ial_pkg.sv =====
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types and constants of the indexed array list.
// ----------------------------------------------------------------------------
package ial_pkg;

	localparam int DEPTH_DEF = 128;
	localparam int POS_W     = 7;
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 8;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_LOCATE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one decoded command as it waits in the queue
	typedef struct packed {
		cmd_t               cmd;
		logic [POS_W-1:0]   pos;
		logic [VAL_W-1:0]   val;
	} item_t;

	// control from the sequencer to the cell row
	typedef struct packed {
		logic               en;
		logic               ins;
		logic               del;
		logic [POS_W-1:0]   pos;
		logic [VAL_W-1:0]   val;
	} cell_ctrl_t;

	typedef struct packed {
		logic [VAL_W-1:0]     value;
		logic [POS_W-1:0]     position;
		logic                 found;
		status_t              status;
		logic [CNT_OUT_W-1:0] count;
	} result_t;

endpackage

// ===== rtl/ial_front.sv =====
// ----------------------------------------------------------------------------
// ial_front
// Input side: takes commands, decodes them and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module ial_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_cmd,
	input  logic [ial_pkg::POS_W-1:0] in_pos,
	input  logic [ial_pkg::VAL_W-1:0] in_val,
	output logic                q_valid,
	output ial_pkg::item_t      q_item,
	input  logic                pop
);

	ial_pkg::item_t ent_q [2];
	ial_pkg::item_t dec;
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     fill_q;
	logic           push;

	always_comb begin
		dec.cmd = ial_pkg::cmd_t'(in_cmd);
		dec.pos = in_pos;
		dec.val = in_val;
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign q_item   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== rtl/ial_cells.sv =====
// ----------------------------------------------------------------------------
// ial_cells
// Row of entry cells. Shifts up on insert and down on delete, compares every
// cell with the search value, and reduces read and locate through a
// two-level registered tree.
// ----------------------------------------------------------------------------
module ial_cells #(
	parameter int DEPTH = ial_pkg::DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                        clk,
	input  ial_pkg::cell_ctrl_t         ctl,
	input  logic [CW-1:0]               count,
	output logic [ial_pkg::VAL_W-1:0]   rd_data,
	output logic                        loc_hit,
	output logic [ial_pkg::POS_W-1:0]   loc_pos
);

	localparam int RD_N = (DEPTH < 128) ? DEPTH : 128;
	localparam int RGS  = 8;
	localparam int RG   = (RD_N + RGS - 1) / RGS;
	localparam int LGS  = 32;
	localparam int LG   = (DEPTH + LGS - 1) / LGS;
	localparam int LIW  = $clog2(LGS);

	logic [ial_pkg::VAL_W-1:0] cell_q [DEPTH];

	logic [ial_pkg::VAL_W-1:0] rd_grp_c   [RG];
	logic [ial_pkg::VAL_W-1:0] rd_grp_s1  [RG];
	logic [3:0]                rd_sel_s1;
	logic                      hit_c      [LG];
	logic [LIW-1:0]            idx_c      [LG];
	logic                      hit_s1     [LG];
	logic [LIW-1:0]            idx_s1     [LG];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (ctl.ins) begin
				if (i == int'(ctl.pos)) begin
					cell_q[i] <= ctl.val;
				end else if (i > int'(ctl.pos)) begin
					if (i > 0) begin
						cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
					end
				end
			end else if (ctl.del) begin
				if (i >= int'(ctl.pos) && i < DEPTH - 1) begin
					cell_q[i] <= cell_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_comb begin
		for (int g = 0; g < RG; g++) begin
			rd_grp_c[g] = '0;
			for (int j = 0; j < RGS; j++) begin
				if (g * RGS + j < RD_N && ctl.pos[2:0] == 3'(j)) begin
					rd_grp_c[g] = cell_q[g * RGS + j];
				end
			end
		end
	end

	always_comb begin
		for (int g = 0; g < LG; g++) begin
			hit_c[g] = 1'b0;
			idx_c[g] = '0;
			for (int j = LGS - 1; j >= 0; j--) begin
				if (g * LGS + j < DEPTH) begin
					if (cell_q[g * LGS + j] == ctl.val && CW'(g * LGS + j) < count) begin
						hit_c[g] = 1'b1;
						idx_c[g] = LIW'(j);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			rd_sel_s1 <= ctl.pos[6:3];
			for (int g = 0; g < RG; g++) begin
				rd_grp_s1[g] <= rd_grp_c[g];
			end
			for (int g = 0; g < LG; g++) begin
				hit_s1[g] <= hit_c[g];
				idx_s1[g] <= idx_c[g];
			end
		end
	end

	always_comb begin
		rd_data = '0;
		for (int g = 0; g < RG; g++) begin
			if (rd_sel_s1 == 4'(g)) begin
				rd_data = rd_grp_s1[g];
			end
		end
	end

	always_comb begin
		loc_hit = 1'b0;
		loc_pos = '0;
		for (int g = LG - 1; g >= 0; g--) begin
			if (hit_s1[g]) begin
				loc_hit = 1'b1;
				loc_pos = ial_pkg::POS_W'(g * LGS + int'(idx_s1[g]));
			end
		end
	end

endmodule

// ===== rtl/ial_back.sv =====
// ----------------------------------------------------------------------------
// ial_back
// Execution side: checks bounds against the entry count, drives the cell
// row and registers one result per command.
// ----------------------------------------------------------------------------
module ial_back #(
	parameter int DEPTH = ial_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  ial_pkg::item_t      q_item,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_ready,
	output ial_pkg::result_t    res
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > ial_pkg::POS_W) ? CW : ial_pkg::POS_W;

	typedef enum logic {
		S_IDLE,
		S_FIN
	} state_t;

	state_t                 state_q;
	logic                   valid_q;
	ial_pkg::result_t       res_q;
	ial_pkg::cmd_t          cmd_s1;
	ial_pkg::status_t       status_s1;
	logic [CW-1:0]          count_q;

	ial_pkg::status_t       st_c;
	logic [CW-1:0]          count_c;
	logic [CMPW-1:0]        pos_x;
	logic [CMPW-1:0]        cnt_x;
	ial_pkg::cell_ctrl_t    ctl;
	logic [ial_pkg::VAL_W-1:0] rd_data;
	logic                   loc_hit;
	logic [ial_pkg::POS_W-1:0] loc_pos;

	assign pop = (state_q == S_IDLE) && q_valid;

	always_comb begin
		pos_x   = CMPW'(q_item.pos);
		cnt_x   = CMPW'(count_q);
		st_c    = ial_pkg::ST_OK;
		count_c = count_q;
		unique case (q_item.cmd)
			ial_pkg::CMD_READ: begin
				if (pos_x >= cnt_x) begin
					st_c = ial_pkg::ST_RANGE;
				end
			end
			ial_pkg::CMD_INSERT: begin
				if (count_q == CW'(DEPTH)) begin
					st_c = ial_pkg::ST_FULL;
				end else if (pos_x > cnt_x) begin
					st_c = ial_pkg::ST_RANGE;
				end else begin
					count_c = count_q + CW'(1);
				end
			end
			ial_pkg::CMD_DELETE: begin
				if (pos_x >= cnt_x) begin
					st_c = ial_pkg::ST_RANGE;
				end else begin
					count_c = count_q - CW'(1);
				end
			end
			default: st_c = ial_pkg::ST_OK;
		endcase
	end

	always_comb begin
		ctl.en  = pop;
		ctl.ins = pop && q_item.cmd == ial_pkg::CMD_INSERT && st_c == ial_pkg::ST_OK;
		ctl.del = pop && q_item.cmd == ial_pkg::CMD_DELETE && st_c == ial_pkg::ST_OK;
		ctl.pos = q_item.pos;
		ctl.val = q_item.val;
	end

	ial_cells #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_cells (
		.clk     (clk),
		.ctl     (ctl),
		.count   (count_q),
		.rd_data (rd_data),
		.loc_hit (loc_hit),
		.loc_pos (loc_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= 1'b0;
			res_q     <= '0;
			cmd_s1    <= ial_pkg::CMD_READ;
			status_s1 <= ial_pkg::ST_OK;
			count_q   <= '0;
		end else begin
			if (state_q == S_FIN && (!valid_q || res_ready)) begin
				valid_q <= 1'b1;
			end else if (valid_q && res_ready) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						cmd_s1    <= q_item.cmd;
						status_s1 <= st_c;
						count_q   <= count_c;
						state_q   <= S_FIN;
					end
				end
				S_FIN: begin
					if (!valid_q || res_ready) begin
						res_q.value    <= (cmd_s1 == ial_pkg::CMD_READ &&
								status_s1 == ial_pkg::ST_OK) ? rd_data : '0;
						res_q.found    <= (cmd_s1 == ial_pkg::CMD_LOCATE) && loc_hit;
						res_q.position <= (cmd_s1 == ial_pkg::CMD_LOCATE && loc_hit) ?
								loc_pos : '0;
						res_q.status   <= status_s1;
						res_q.count    <= ial_pkg::CNT_OUT_W'(count_q);
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/indexed_array_list.sv =====
// ----------------------------------------------------------------------------
// indexed_array_list
// Ordered list of signed 32-bit values with read, insert, delete and locate.
//
//  channel  | dir | tdata bits
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | 48: command, position_in, value_in
//  m_axis   | out | 56: value_out, position_out, found, status, count_out
//
// A command passes through the execution states S_IDLE (bounds check, shift
// and first reduction level) and S_FIN (final read/locate selection).
// A new command is not taken until the previous one has left S_FIN.
// A two-entry queue decouples input from execution; a stalled output holds
// execution in S_FIN while the queue keeps filling.
// Reset clears the count and the queues; entry contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_array_list #(
	parameter int DEPTH = ial_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // command[1:0], position_in[8:2], value_in[40:9]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata    // value_out[31:0], position_out[38:32],
	                                    // found[39], status[41:40], count_out[49:42]
);

	logic               q_valid;
	ial_pkg::item_t     q_item;
	logic               pop;
	ial_pkg::result_t   res;

	ial_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tdata[1:0]),
		.in_pos   (s_axis_tdata[8:2]),
		.in_val   (s_axis_tdata[40:9]),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.pop      (pop)
	);

	ial_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tdata = {6'd0, res.count, res.status, res.found, res.position, res.value};

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.status == ial_pkg::ST_FULL
		|-> res.count == ial_pkg::CNT_OUT_W'(DEPTH))
		else $error("full status without full count");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.status != ial_pkg::ST_OK
		|-> res.value == '0 && !res.found && res.position == '0)
		else $error("failed command carries data");

endmodule
